>>> rtl/core/mva_pkg.sv
package mva_pkg;

	localparam int VOICES_DEF = 64;
	localparam int CHANNELS   = 16;
	localparam int AGE_W      = 32;
	localparam int RAM_W      = 4 + 7 + AGE_W;

	localparam logic signed [18:0] BEND_MAX = 19'sd196608;
	localparam logic signed [18:0] BEND_MIN = -19'sd196608;

	localparam logic [6:0] CC_SUSTAIN  = 7'd64;
	localparam logic [6:0] CC_ALL_OFF  = 7'd123;
	localparam logic [6:0] CC_ALL_KILL = 7'd120;
	localparam logic [6:0] PEDAL_DOWN  = 7'd64;

	typedef enum logic [2:0] {
		REQ_NOTE_ON   = 3'd0,
		REQ_NOTE_OFF  = 3'd1,
		REQ_BEND      = 3'd2,
		REQ_CHAN_PRES = 3'd3,
		REQ_POLY_PRES = 3'd4,
		REQ_CTRL      = 3'd5
	} req_t;

	typedef enum logic [2:0] {
		ACT_FRESH   = 3'd0,
		ACT_RETRIG  = 3'd1,
		ACT_RELEASE = 3'd2,
		ACT_KILL    = 3'd3,
		ACT_RETUNE  = 3'd4,
		ACT_SETPRES = 3'd5
	} act_t;

	typedef enum logic [2:0] {
		OP_NOTE_ON,
		OP_NOTE_OFF,
		OP_BEND,
		OP_CHAN_PRES,
		OP_POLY_PRES,
		OP_SUSTAIN,
		OP_ALL_OFF,
		OP_ALL_KILL
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_POST,
		ST_FIN
	} st_t;

	typedef struct packed {
		logic [5:0]        voice;
		act_t              action;
		logic [3:0]        chan;
		logic [6:0]        note;
		logic [6:0]        vel;
		logic [6:0]        pres;
		logic signed [18:0] bend;
	} cmd_t;

	typedef struct packed {
		logic chan_hit;
		logic key_hit;
		logic rel_better;
		logic all_better;
	} match_t;

endpackage

>>> rtl/core/mva_ram.sv
module mva_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, hold when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/mva_match.sv
module mva_match (
	input  logic [3:0]                 rd_chan,
	input  logic [6:0]                 rd_key,
	input  logic [mva_pkg::AGE_W-1:0]  rd_age,
	input  logic                       active,
	input  logic                       releasing,
	input  logic [3:0]                 ch,
	input  logic [6:0]                 key,
	input  logic                       rel_found,
	input  logic [mva_pkg::AGE_W-1:0]  rel_age,
	input  logic                       all_found,
	input  logic [mva_pkg::AGE_W-1:0]  all_age,
	output mva_pkg::match_t            res
);
	import mva_pkg::*;

	// compare one voice entry against the event and the running minima
	always_comb begin
		res.chan_hit   = active && (rd_chan == ch);
		res.key_hit    = active && (rd_chan == ch) && (rd_key == key);
		res.rel_better = releasing && (!rel_found || (rd_age < rel_age));
		res.all_better = !all_found || (rd_age < all_age);
	end

endmodule

>>> rtl/core/mva_out.sv
module mva_out (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mva_pkg::cmd_t  push_data,
	output logic           push_ready,
	input  logic           finish,
	output logic           finish_done,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [55:0]    m_tdata,
	output logic           m_tlast
);
	import mva_pkg::*;

	logic pend_v_q;
	cmd_t pend_q;
	logic out_v_q;
	cmd_t out_q;
	logic last_q;
	logic out_free;

	assign out_free    = !out_v_q || m_tready;
	assign push_ready  = !pend_v_q || out_free;
	assign finish_done = !pend_v_q || out_free;

	// hold one word back so the final one can be marked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_v_q && m_tready) begin
				out_v_q <= 1'b0;
			end
			if (push && push_ready) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					out_v_q <= 1'b1;
				end
			end else if (finish && pend_v_q && out_free) begin
				pend_v_q <= 1'b0;
				out_v_q  <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (push && push_ready) begin
			pend_q <= push_data;
			if (pend_v_q) begin
				out_q  <= pend_q;
				last_q <= 1'b0;
			end
		end else if (finish && pend_v_q && out_free) begin
			out_q  <= pend_q;
			last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {3'b000, out_q.bend, out_q.pres, out_q.vel, out_q.note,
		out_q.chan, out_q.action, out_q.voice};

endmodule

>>> rtl/core/midi_voice_allocator_core.sv
// MIDI voice allocator core.
// Input channel s_*: one decoded MIDI event per word, type in s_tuser.
// Output channel m_*: voice commands for an oscillator bank; m_tlast marks
// the final command of an event. An event may cause no command at all.
// cfg_we/cfg_wdata set the number of voices in use (saturated to 1..VOICES);
// write it only while the block is idle.
// Each event is handled by one sequential scan over the voices in use: the
// voice table RAM has one registered read port, so every voice takes a read
// state and an evaluate state, and the scan waits while the output cannot
// take a command. Events that are not understood are dropped; s_tready is
// high only between events.
// Commands go through a one-word hold stage and an output register, so a
// stalled receiver stops the scan at the next command but the last command
// can wait at the output while a new event is taken.
// Reset clears all voice flags, channel state and the age counter, and sets
// the voice count to 16; the block is ready as soon as reset is released.
module midi_voice_allocator_core #(
	parameter int VOICES = mva_pkg::VOICES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // channel, key, amount, bend_fixed, zero pad
	input  logic [2:0]  s_tuser,  // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // voice, action, voice_channel, voice_note,
	                              // velocity, pressure, bend, zero pad
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata
);
	import mva_pkg::*;

	localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam logic [6:0] VMAX = 7'(VOICES);

	// input fields
	logic [3:0]        in_ch;
	logic [6:0]        in_key;
	logic [6:0]        in_amt;
	logic signed [18:0] in_bend;
	logic signed [18:0] bend_sat;
	assign in_ch   = s_tdata[3:0];
	assign in_key  = s_tdata[10:4];
	assign in_amt  = s_tdata[17:11];
	assign in_bend = s_tdata[36:18];

	always_comb begin
		if (in_bend > BEND_MAX) bend_sat = BEND_MAX;
		else if (in_bend < BEND_MIN) bend_sat = BEND_MIN;
		else bend_sat = in_bend;
	end

	// state
	st_t state_q, state_d;
	op_t op_q, op_d;
	logic known;
	logic [6:0] vc_q;
	logic [6:0] n_lim;
	logic [IW-1:0] last_idx;

	logic [VOICES-1:0] act_q, rel_q, held_q, ped_q;
	logic signed [18:0] chan_bend_q [CHANNELS];
	logic [6:0]  chan_pres_q [CHANNELS];
	logic [CHANNELS-1:0] sus_q;
	logic [AGE_W-1:0] age_ctr_q;

	logic [3:0] ch_q;
	logic [6:0] key_q, amt_q;
	logic down_q, sus_rel_q;
	logic [IW-1:0] idx_q;
	logic found_q, free_q, relf_q, allf_q;
	logic [IW-1:0] fidx_q, freeidx_q, relidx_q, allidx_q;
	logic [AGE_W-1:0] relage_q, allage_q;

	// voice table RAM
	logic ram_we, ram_re;
	logic [IW-1:0] tgt;
	logic [RAM_W-1:0] ram_wdata, ram_rdata;
	logic [3:0] rd_chan;
	logic [6:0] rd_key;
	logic [AGE_W-1:0] rd_age;
	assign ram_wdata = {ch_q, key_q, age_ctr_q};
	assign rd_chan = ram_rdata[RAM_W-1 -: 4];
	assign rd_key  = ram_rdata[AGE_W +: 7];
	assign rd_age  = ram_rdata[AGE_W-1:0];

	mva_ram #(.WIDTH(RAM_W), .DEPTH(VOICES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tgt),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	match_t mres;
	mva_match u_match (
		.rd_chan   (rd_chan),
		.rd_key    (rd_key),
		.rd_age    (rd_age),
		.active    (act_q[idx_q]),
		.releasing (rel_q[idx_q]),
		.ch        (ch_q),
		.key       (key_q),
		.rel_found (relf_q),
		.rel_age   (relage_q),
		.all_found (allf_q),
		.all_age   (allage_q),
		.res       (mres)
	);

	logic push, push_ready, finish, finish_done;
	cmd_t push_data;
	mva_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_data   (push_data),
		.push_ready  (push_ready),
		.finish      (finish),
		.finish_done (finish_done),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

	// pool size in use
	always_comb begin
		if (vc_q == 7'd0) n_lim = 7'd1;
		else if (vc_q > VMAX) n_lim = VMAX;
		else n_lim = vc_q;
		last_idx = IW'(n_lim - 7'd1);
	end

	// decode the incoming event
	always_comb begin
		known = 1'b1;
		op_d  = OP_NOTE_ON;
		unique case (s_tuser)
			REQ_NOTE_ON:   op_d = OP_NOTE_ON;
			REQ_NOTE_OFF:  op_d = OP_NOTE_OFF;
			REQ_BEND:      op_d = OP_BEND;
			REQ_CHAN_PRES: op_d = OP_CHAN_PRES;
			REQ_POLY_PRES: op_d = OP_POLY_PRES;
			REQ_CTRL: begin
				if (in_key == CC_SUSTAIN) op_d = OP_SUSTAIN;
				else if (in_key == CC_ALL_OFF) op_d = OP_ALL_OFF;
				else if (in_key == CC_ALL_KILL) op_d = OP_ALL_KILL;
				else known = 1'b0;
			end
			default: known = 1'b0;
		endcase
	end

	// per-voice decisions during the scan
	logic scan_end, eval_push, eval_go, post_push, post_go;
	act_t eval_act;
	always_comb begin
		scan_end  = (idx_q == last_idx);
		eval_push = 1'b0;
		eval_act  = ACT_RETUNE;
		case (op_q)
			OP_BEND: begin
				eval_push = mres.chan_hit;
				eval_act  = ACT_RETUNE;
			end
			OP_CHAN_PRES: begin
				eval_push = mres.chan_hit;
				eval_act  = ACT_SETPRES;
			end
			OP_SUSTAIN: begin
				eval_push = mres.chan_hit && ped_q[idx_q] && sus_rel_q;
				eval_act  = ACT_RELEASE;
			end
			OP_ALL_OFF: begin
				eval_push = mres.chan_hit;
				eval_act  = ACT_RELEASE;
			end
			OP_ALL_KILL: begin
				eval_push = mres.chan_hit;
				eval_act  = ACT_KILL;
			end
			default: eval_push = 1'b0;
		endcase
		eval_go = !eval_push || push_ready;
	end

	// command after the scan
	act_t post_act;
	always_comb begin
		post_push = 1'b0;
		post_act  = ACT_RETRIG;
		tgt       = fidx_q;
		case (op_q)
			OP_NOTE_ON: begin
				post_push = 1'b1;
				if (found_q) begin
					tgt = fidx_q;
					post_act = ACT_RETRIG;
				end else if (free_q) begin
					tgt = freeidx_q;
					post_act = ACT_FRESH;
				end else if (relf_q) begin
					tgt = relidx_q;
					post_act = ACT_RETRIG;
				end else begin
					tgt = allidx_q;
					post_act = ACT_RETRIG;
				end
			end
			OP_NOTE_OFF: begin
				post_push = found_q && held_q[fidx_q] && !sus_q[ch_q];
				post_act  = ACT_RELEASE;
			end
			OP_POLY_PRES: begin
				post_push = found_q;
				post_act  = ACT_SETPRES;
			end
			default: post_push = 1'b0;
		endcase
		post_go = !post_push || push_ready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid && known) state_d = ST_READ;
			ST_READ: state_d = ST_EVAL;
			ST_EVAL: if (eval_go) state_d = scan_end ? ST_POST : ST_READ;
			ST_POST: if (post_go) state_d = ST_FIN;
			ST_FIN:  if (finish_done) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		push      = 1'b0;
		finish    = 1'b0;
		push_data = '0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_READ: ram_re = 1'b1;
			ST_EVAL: begin
				push             = eval_push;
				push_data.voice  = 6'(idx_q);
				push_data.action = eval_act;
				push_data.chan   = rd_chan;
				push_data.note   = rd_key;
				push_data.pres   = (op_q == OP_CHAN_PRES) ? amt_q : 7'd0;
				push_data.bend   = chan_bend_q[ch_q];
			end
			ST_POST: begin
				push             = post_push;
				ram_we           = (op_q == OP_NOTE_ON) && post_go;
				push_data.voice  = 6'(tgt);
				push_data.action = post_act;
				push_data.chan   = ch_q;
				push_data.note   = key_q;
				push_data.vel    = (op_q == OP_NOTE_ON) ? amt_q : 7'd0;
				if (op_q == OP_NOTE_ON) push_data.pres = chan_pres_q[ch_q];
				else if (op_q == OP_POLY_PRES) push_data.pres = amt_q;
				else push_data.pres = 7'd0;
				push_data.bend   = chan_bend_q[ch_q];
			end
			ST_FIN: finish = 1'b1;
			default: s_tready = 1'b0;
		endcase
	end

	// control and table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			vc_q      <= 7'd16;
			act_q     <= '0;
			rel_q     <= '0;
			held_q    <= '0;
			ped_q     <= '0;
			sus_q     <= '0;
			age_ctr_q <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				chan_bend_q[c] <= '0;
				chan_pres_q[c] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) vc_q <= cfg_wdata;

			// update channel state on accept
			if (state_q == ST_IDLE && s_tvalid && known) begin
				if (op_d == OP_BEND) chan_bend_q[in_ch] <= bend_sat;
				if (op_d == OP_CHAN_PRES) chan_pres_q[in_ch] <= in_amt;
			end

			// release or kill while scanning
			if (state_q == ST_EVAL && eval_go && eval_push) begin
				if (op_q == OP_ALL_KILL) begin
					act_q[idx_q] <= 1'b0;
				end else if (op_q == OP_SUSTAIN || op_q == OP_ALL_OFF) begin
					rel_q[idx_q]  <= 1'b1;
					held_q[idx_q] <= 1'b0;
					ped_q[idx_q]  <= 1'b0;
				end
			end

			// apply the event's outcome
			if (state_q == ST_POST && post_go) begin
				case (op_q)
					OP_NOTE_ON: begin
						act_q[tgt]  <= 1'b1;
						rel_q[tgt]  <= 1'b0;
						held_q[tgt] <= 1'b1;
						ped_q[tgt]  <= 1'b0;
						age_ctr_q   <= age_ctr_q + 1'b1;
					end
					OP_NOTE_OFF: begin
						if (found_q && held_q[fidx_q]) begin
							held_q[fidx_q] <= 1'b0;
							if (sus_q[ch_q]) begin
								ped_q[fidx_q] <= 1'b1;
							end else begin
								rel_q[fidx_q] <= 1'b1;
								ped_q[fidx_q] <= 1'b0;
							end
						end
					end
					OP_SUSTAIN: sus_q[ch_q] <= down_q;
					OP_ALL_OFF, OP_ALL_KILL: sus_q[ch_q] <= 1'b0;
					default: sus_q <= sus_q;
				endcase
			end
		end
	end

	// event and scan registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid && known) begin
			op_q      <= op_d;
			ch_q      <= in_ch;
			key_q     <= in_key;
			amt_q     <= in_amt;
			down_q    <= (in_amt >= PEDAL_DOWN);
			sus_rel_q <= (in_amt < PEDAL_DOWN) && sus_q[in_ch];
			idx_q     <= '0;
			found_q   <= 1'b0;
			free_q    <= 1'b0;
			relf_q    <= 1'b0;
			allf_q    <= 1'b0;
		end else if (state_q == ST_EVAL && eval_go) begin
			if (!scan_end) idx_q <= idx_q + 1'b1;
			// first matching voice
			if (mres.key_hit && !found_q) begin
				found_q <= 1'b1;
				fidx_q  <= idx_q;
			end
			// lowest free voice
			if (!act_q[idx_q] && !free_q) begin
				free_q    <= 1'b1;
				freeidx_q <= idx_q;
			end
			// oldest releasing and oldest overall
			if (mres.rel_better) begin
				relf_q   <= 1'b1;
				relidx_q <= idx_q;
				relage_q <= rd_age;
			end
			if (mres.all_better) begin
				allf_q   <= 1'b1;
				allidx_q <= idx_q;
				allage_q <= rd_age;
			end
		end
	end

endmodule
